### hw/rtl/cnf_tautology_clause_counter_unit_defines.svh
// ============================================================================
// Assertion macros for the CNF tautology clause counter
// Shared helpers so that assertion code compiles away in synthesis builds.
// ============================================================================
`ifndef CNF_TAUTOLOGY_CLAUSE_COUNTER_UNIT_DEFINES_SVH
`define CNF_TAUTOLOGY_CLAUSE_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clock, disabled in reset.
`define CTCC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctcc: same-cycle check failed");
// Next-cycle implication, sampled on clock, disabled in reset.
`define CTCC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctcc: next-cycle check failed");
`else
`define CTCC_ASSERT_IMPL(name, ante, cons)
`define CTCC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### hw/rtl/ctcc_pkg.sv
// ============================================================================
// ctcc_pkg
// Types, constants and helpers for the CNF tautology clause counter.
// ============================================================================
`timescale 1ns / 1ps

package ctcc_pkg;

   // Literal and tag store geometry.
   localparam int unsigned LitBits     = 13;
   localparam int unsigned MaxVars     = 4095;
   localparam int unsigned TagDepth    = 4096;
   localparam int unsigned AddrBits    = 12;
   localparam int unsigned SerialBits  = 32;
   localparam int unsigned PolBits     = 2;
   localparam int unsigned TagBits     = SerialBits + PolBits;

   // Counter and result queue sizing.
   localparam int unsigned CountBits   = 24;
   localparam int unsigned FifoDepth   = 4;
   localparam int unsigned FifoPtrBits = 2;
   localparam int unsigned FifoCntBits = 3;

   // Polarity codes as stored in a tag entry.
   typedef logic [PolBits-1:0] pol_type;
   localparam pol_type PolNone = 2'b00;
   localparam pol_type PolPos  = 2'b01;
   localparam pol_type PolNeg  = 2'b10;

   // One tag store entry: clause serial that last touched it plus polarities.
   typedef struct packed {
      logic [SerialBits-1:0] serial;
      pol_type               pol;
   } tag_type;

   // One result transaction.
   typedef struct packed {
      logic                 clause_is_tautology;
      logic [CountBits-1:0] tautology_count;
      logic [CountBits-1:0] other_count;
      logic                 formula_done;
      logic                 all_tautologies;
      logic                 bad_literal_seen;
   } rsp_type;

   // Magnitude of a two's complement literal; the most negative code maps
   // to one past the largest positive variable.
   function automatic logic [LitBits-1:0] lit_mag(input logic [LitBits-1:0] lit);
      logic [LitBits-1:0] neg_val;
      neg_val = '0 - lit;
      return lit[LitBits-1] ? neg_val : lit;
   endfunction

   // Saturating increment of a clause counter.
   function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
      return (v == '1) ? v : v + CountBits'(1);
   endfunction

endpackage

### hw/rtl/ctcc_ram.sv
// ============================================================================
// ctcc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
// ============================================================================
`timescale 1ns / 1ps

module ctcc_ram #(
   parameter int unsigned DATA_WIDTH = 8,
   parameter int unsigned DEPTH      = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cnf_tautology_clause_counter_unit.sv
// The block reads one signed CNF literal per clock cycle while not stalled
// and ends a clause on a zero literal, which yields one result transaction
// with the clause verdict, running counts and formula flags. The rate is
// set by one read-modify-write of the 4096-entry tag store per literal: the
// read is issued as the literal is accepted, the update is written in the
// cycle after, and a forwarding register covers a literal that follows on
// the same variable. After reset, and again whenever the 32-bit clause
// serial wraps, a clearing pass writes every tag entry while no literal is
// accepted; configuration writes are taken throughout. Input is held off on a
// serial wrap, while clearing, or when the four-entry result queue could fill.
// ============================================================================
// cnf_tautology_clause_counter_unit
// Counts tautological clauses in a stream of CNF literals.
// ============================================================================
`timescale 1ns / 1ps
`include "cnf_tautology_clause_counter_unit_defines.svh"

module cnf_tautology_clause_counter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Literal input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ctcc_pkg::LitBits-1:0] req_literal,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_clause_is_tautology,
   output logic [ctcc_pkg::CountBits-1:0]      rsp_tautology_count,
   output logic [ctcc_pkg::CountBits-1:0]      rsp_other_count,
   output logic                                rsp_formula_done,
   output logic                                rsp_all_tautologies,
   output logic                                rsp_bad_literal_seen,
   // Configuration port.
   input  logic                                csr_wr_en,
   input  logic [ctcc_pkg::CountBits-1:0]      csr_wr_data
);

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   logic                                 accept_w;
   logic [ctcc_pkg::LitBits-1:0]         req_mag_w;

   logic                                 s1_valid_ff, s1_valid_in;
   logic [ctcc_pkg::LitBits-1:0]         s1_lit_ff;
   logic [ctcc_pkg::LitBits-1:0]         s1_mag_w;
   logic                                 s1_neg_w;
   logic                                 s1_zero_w;
   logic                                 s1_bad_w;
   logic [ctcc_pkg::AddrBits-1:0]        s1_addr_w;

   logic                                 clearing_ff, clearing_in;
   logic [ctcc_pkg::AddrBits-1:0]        clear_cnt_ff, clear_cnt_in;

   logic                                 fwd_valid_ff;
   logic [ctcc_pkg::AddrBits-1:0]        fwd_addr_ff;
   ctcc_pkg::tag_type                    fwd_data_ff;

   logic                                 ram_wr_en;
   logic [ctcc_pkg::AddrBits-1:0]        ram_wr_addr;
   ctcc_pkg::tag_type                    ram_wr_data;
   logic [ctcc_pkg::TagBits-1:0]         ram_rd_data;

   ctcc_pkg::tag_type                    tag_cur_w;
   ctcc_pkg::pol_type                    pol_cur_w;
   ctcc_pkg::pol_type                    pol_mine_w;
   ctcc_pkg::pol_type                    pol_other_w;

   logic [ctcc_pkg::CountBits-1:0]       expected_ff;
   logic [ctcc_pkg::SerialBits-1:0]      serial_ff, serial_in;
   logic                                 hit_ff, hit_in;
   logic                                 bad_ff, bad_in;
   logic                                 restart_ff, restart_in;
   logic [ctcc_pkg::CountBits-1:0]       taut_ff, taut_in;
   logic [ctcc_pkg::CountBits-1:0]       plain_ff, plain_in;
   logic [ctcc_pkg::CountBits-1:0]       seen_ff, seen_in;
   logic [ctcc_pkg::CountBits-1:0]       taut_base_w, plain_base_w, seen_base_w;
   logic [ctcc_pkg::CountBits-1:0]       taut_new_w, plain_new_w, seen_new_w;
   logic                                 done_w;
   logic                                 wrap_w;

   ctcc_pkg::rsp_type                    fifo_ff [ctcc_pkg::FifoDepth];
   logic [ctcc_pkg::FifoPtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ctcc_pkg::FifoPtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ctcc_pkg::FifoCntBits-1:0]     fifo_cnt_ff, fifo_cnt_in;
   logic [ctcc_pkg::FifoCntBits-1:0]     fifo_need_w;
   ctcc_pkg::rsp_type                    push_data_w;
   ctcc_pkg::rsp_type                    head_w;
   logic                                 push_w;
   logic                                 pop_w;

   // ------------------------------------------------------------------------
   // Input handshake; the tag read is issued as a literal is accepted.
   // ------------------------------------------------------------------------
   assign wrap_w      = s1_valid_ff && s1_zero_w && (serial_ff == '1);
   assign fifo_need_w = fifo_cnt_ff + ctcc_pkg::FifoCntBits'(s1_valid_ff && s1_zero_w);
   assign req_stall   = clearing_ff || wrap_w ||
                        (fifo_need_w >= ctcc_pkg::FifoCntBits'(ctcc_pkg::FifoDepth));
   assign accept_w    = req_valid && !req_stall;
   assign req_mag_w   = ctcc_pkg::lit_mag(req_literal);

   // ------------------------------------------------------------------------
   // Tag store
   // ------------------------------------------------------------------------
   ctcc_ram #(
      .DATA_WIDTH (ctcc_pkg::TagBits),
      .DEPTH      (ctcc_pkg::TagDepth)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept_w),
      .rd_addr (req_mag_w[ctcc_pkg::AddrBits-1:0]),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Literal decode in the update stage.
   // ------------------------------------------------------------------------
   assign s1_valid_in = accept_w;
   assign s1_neg_w    = s1_lit_ff[ctcc_pkg::LitBits-1];
   assign s1_mag_w    = ctcc_pkg::lit_mag(s1_lit_ff);
   assign s1_zero_w   = (s1_mag_w == '0);
   assign s1_bad_w    = (s1_mag_w > ctcc_pkg::LitBits'(ctcc_pkg::MaxVars));
   assign s1_addr_w   = s1_mag_w[ctcc_pkg::AddrBits-1:0];

   // The write made on the accept edge is not in the read data yet.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_w)) begin
         tag_cur_w = fwd_data_ff;
      end else begin
         tag_cur_w = ctcc_pkg::tag_type'(ram_rd_data);
      end
   end

   // An entry stamped by another clause counts as empty.
   assign pol_cur_w   = (tag_cur_w.serial == serial_ff) ? tag_cur_w.pol : ctcc_pkg::PolNone;
   assign pol_mine_w  = s1_neg_w ? ctcc_pkg::PolNeg : ctcc_pkg::PolPos;
   assign pol_other_w = s1_neg_w ? ctcc_pkg::PolPos : ctcc_pkg::PolNeg;

   // Tag store writes: the clearing pass, or the update of a good literal.
   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en          = s1_valid_ff && !s1_zero_w && !s1_bad_w;
         ram_wr_addr        = s1_addr_w;
         ram_wr_data.serial = serial_ff;
         ram_wr_data.pol    = pol_cur_w | pol_mine_w;
      end
   end

   // Clearing pass sequencing.
   always_comb begin
      clearing_in  = clearing_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clearing_ff) begin
         clear_cnt_in = clear_cnt_ff + ctcc_pkg::AddrBits'(1);
         if (clear_cnt_ff == '1) begin
            clearing_in = 1'b0;
         end
      end else if (wrap_w) begin
         clearing_in  = 1'b1;
         clear_cnt_in = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Clause and formula state.
   // ------------------------------------------------------------------------
   assign taut_base_w  = restart_ff ? '0 : taut_ff;
   assign plain_base_w = restart_ff ? '0 : plain_ff;
   assign seen_base_w  = restart_ff ? '0 : seen_ff;
   assign taut_new_w   = hit_ff ? ctcc_pkg::sat_inc(taut_base_w) : taut_base_w;
   assign plain_new_w  = hit_ff ? plain_base_w : ctcc_pkg::sat_inc(plain_base_w);
   assign seen_new_w   = ctcc_pkg::sat_inc(seen_base_w);
   assign done_w       = (expected_ff != '0) && (seen_new_w == expected_ff);

   always_comb begin
      serial_in  = serial_ff;
      hit_in     = hit_ff;
      bad_in     = bad_ff;
      restart_in = restart_ff;
      taut_in    = taut_ff;
      plain_in   = plain_ff;
      seen_in    = seen_ff;
      if (s1_valid_ff) begin
         restart_in = 1'b0;
         taut_in    = taut_base_w;
         plain_in   = plain_base_w;
         seen_in    = seen_base_w;
         if (s1_zero_w) begin
            taut_in    = taut_new_w;
            plain_in   = plain_new_w;
            seen_in    = seen_new_w;
            restart_in = done_w;
            hit_in     = 1'b0;
            bad_in     = 1'b0;
            serial_in  = wrap_w ? ctcc_pkg::SerialBits'(1)
                                : serial_ff + ctcc_pkg::SerialBits'(1);
         end else if (s1_bad_w) begin
            bad_in = 1'b1;
         end else if ((pol_cur_w & pol_other_w) != ctcc_pkg::PolNone) begin
            hit_in = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result queue.
   // ------------------------------------------------------------------------
   assign push_w = s1_valid_ff && s1_zero_w;
   assign pop_w  = rsp_valid && !rsp_stall;

   always_comb begin
      push_data_w.clause_is_tautology = hit_ff;
      push_data_w.tautology_count     = taut_new_w;
      push_data_w.other_count         = plain_new_w;
      push_data_w.formula_done        = done_w;
      push_data_w.all_tautologies     = done_w && (plain_new_w == '0);
      push_data_w.bad_literal_seen    = bad_ff;
   end

   assign wr_ptr_in = push_w ? wr_ptr_ff + ctcc_pkg::FifoPtrBits'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop_w ? rd_ptr_ff + ctcc_pkg::FifoPtrBits'(1) : rd_ptr_ff;

   always_comb begin
      case ({push_w, pop_w})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + ctcc_pkg::FifoCntBits'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - ctcc_pkg::FifoCntBits'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   assign head_w                  = fifo_ff[rd_ptr_ff];
   assign rsp_valid               = (fifo_cnt_ff != '0);
   assign rsp_clause_is_tautology = head_w.clause_is_tautology;
   assign rsp_tautology_count     = head_w.tautology_count;
   assign rsp_other_count         = head_w.other_count;
   assign rsp_formula_done        = head_w.formula_done;
   assign rsp_all_tautologies     = head_w.all_tautologies;
   assign rsp_bad_literal_seen    = head_w.bad_literal_seen;

   // ------------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
         fwd_valid_ff <= 1'b0;
         expected_ff  <= '0;
         serial_ff    <= ctcc_pkg::SerialBits'(1);
         hit_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         restart_ff   <= 1'b0;
         taut_ff      <= '0;
         plain_ff     <= '0;
         seen_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fifo_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
         fwd_valid_ff <= ram_wr_en;
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
         serial_ff    <= serial_in;
         hit_ff       <= hit_in;
         bad_ff       <= bad_in;
         restart_ff   <= restart_in;
         taut_ff      <= taut_in;
         plain_ff     <= plain_in;
         seen_ff      <= seen_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fifo_cnt_ff  <= fifo_cnt_in;
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept_w) begin
         s1_lit_ff <= req_literal;
      end
      fwd_addr_ff <= ram_wr_addr;
      fwd_data_ff <= ram_wr_data;
      if (push_w) begin
         fifo_ff[wr_ptr_ff] <= push_data_w;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `CTCC_ASSERT_IMPL(a_queue_no_overflow, push_w, (fifo_cnt_ff != ctcc_pkg::FifoCntBits'(ctcc_pkg::FifoDepth)) || pop_w)
   `CTCC_ASSERT_IMPL(a_clear_excludes_update, clearing_ff, !s1_valid_ff)
   `CTCC_ASSERT_NEXT(a_wrap_starts_clear, wrap_w, clearing_ff && (serial_ff == ctcc_pkg::SerialBits'(1)))
   `CTCC_ASSERT_NEXT(a_done_arms_restart, push_w && done_w, restart_ff)

endmodule

### dv/cnf_tautology_clause_counter_unit_tb.sv
// ============================================================================
// cnf_tautology_clause_counter_unit_tb
// Streams signed CNF literals into the clause counter and checks every clause
// verdict, running count and formula flag against a predictor kept in the
// bench. Random idle bursts fall on both channels. One long receiver hold
// backs the block up into its input, and the clause target changes between
// phases while the block is idle.
// ============================================================================
`timescale 1ns / 1ps

module cnf_tautology_clause_counter_unit_tb;

   localparam int WatchdogLimit = 20000;
   localparam int LongHoldCycles = 300;
   localparam int SettleCycles = 8;
   localparam int MagBits = ctcc_pkg::LitBits + 1;

   // Block ports; the inputs are all known from time zero.
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [ctcc_pkg::LitBits-1:0] req_literal = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_clause_is_tautology;
   logic [ctcc_pkg::CountBits-1:0]      rsp_tautology_count;
   logic [ctcc_pkg::CountBits-1:0]      rsp_other_count;
   logic                                rsp_formula_done;
   logic                                rsp_all_tautologies;
   logic                                rsp_bad_literal_seen;
   logic                                csr_wr_en = 1'b0;
   logic [ctcc_pkg::CountBits-1:0]      csr_wr_data = '0;

   // Literals waiting to be offered and clause verdicts waiting to arrive.
   logic [ctcc_pkg::LitBits-1:0] pending_literals [$];
   ctcc_pkg::rsp_type            predicted_verdicts [$];

   // Predictor state: per-variable clause stamp and polarities seen.
   logic [ctcc_pkg::SerialBits-1:0] var_stamp [ctcc_pkg::TagDepth];
   ctcc_pkg::pol_type               var_seen [ctcc_pkg::TagDepth];
   logic [ctcc_pkg::SerialBits-1:0] clause_id = 1;
   logic                            clause_hit = 1'b0;
   logic                            clause_bad = 1'b0;
   logic [ctcc_pkg::CountBits-1:0]  taut_total = '0;
   logic [ctcc_pkg::CountBits-1:0]  plain_total = '0;
   logic [ctcc_pkg::CountBits-1:0]  clauses_total = '0;
   logic                            formula_restart = 1'b0;
   logic [ctcc_pkg::CountBits-1:0]  clause_target = '0;

   // Traffic shaping controls.
   bit sender_idle = 1'b0;
   bit receiver_idle = 1'b0;
   bit quiet = 1'b0;
   int holds_asked = 0;
   int holds_served = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   // Run statistics.
   int error_count = 0;
   int literals_accepted = 0;
   int clauses_checked = 0;
   int taut_seen = 0;
   int done_seen = 0;
   int bad_seen = 0;

   cnf_tautology_clause_counter_unit i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_literal             (req_literal),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_clause_is_tautology (rsp_clause_is_tautology),
      .rsp_tautology_count     (rsp_tautology_count),
      .rsp_other_count         (rsp_other_count),
      .rsp_formula_done        (rsp_formula_done),
      .rsp_all_tautologies     (rsp_all_tautologies),
      .rsp_bad_literal_seen    (rsp_bad_literal_seen),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Saturating clause counter step.
   function automatic logic [ctcc_pkg::CountBits-1:0] count_up(
      input logic [ctcc_pkg::CountBits-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Applies one accepted literal to the predictor; a zero closes the clause
   // and queues the verdict the block must report.
   function automatic void tally_literal(input logic [ctcc_pkg::LitBits-1:0] code);
      logic [MagBits-1:0]            mag;
      logic [ctcc_pkg::AddrBits-1:0] slot;
      ctcc_pkg::pol_type             mine;
      ctcc_pkg::pol_type             other;
      ctcc_pkg::pol_type             seen;
      ctcc_pkg::rsp_type             verdict;
      bit                            done;

      // The first input after a finished formula starts a new one.
      if (formula_restart) begin
         taut_total = '0;
         plain_total = '0;
         clauses_total = '0;
         formula_restart = 1'b0;
      end

      mag = code[ctcc_pkg::LitBits-1] ? (MagBits'(1 << ctcc_pkg::LitBits) - {1'b0, code})
                                      : {1'b0, code};
      if (mag != 0) begin
         if (mag > ctcc_pkg::MaxVars) begin
            clause_bad = 1'b1;
         end else begin
            slot = mag[ctcc_pkg::AddrBits-1:0];
            mine = code[ctcc_pkg::LitBits-1] ? ctcc_pkg::PolNeg : ctcc_pkg::PolPos;
            other = code[ctcc_pkg::LitBits-1] ? ctcc_pkg::PolPos : ctcc_pkg::PolNeg;
            seen = (var_stamp[slot] == clause_id) ? var_seen[slot] : ctcc_pkg::PolNone;
            if ((seen & other) != ctcc_pkg::PolNone) clause_hit = 1'b1;
            var_seen[slot] = seen | mine;
            var_stamp[slot] = clause_id;
         end
         return;
      end

      if (clause_hit) taut_total = count_up(taut_total);
      else plain_total = count_up(plain_total);
      clauses_total = count_up(clauses_total);
      done = (clause_target != 0) && (clauses_total == clause_target);

      verdict.clause_is_tautology = clause_hit;
      verdict.tautology_count = taut_total;
      verdict.other_count = plain_total;
      verdict.formula_done = done;
      verdict.all_tautologies = done && (plain_total == 0);
      verdict.bad_literal_seen = clause_bad;
      predicted_verdicts.push_back(verdict);

      formula_restart = done;
      clause_hit = 1'b0;
      clause_bad = 1'b0;
      // A wrapping clause serial empties the whole store.
      if (clause_id == '1) begin
         for (int i = 0; i < ctcc_pkg::TagDepth; i++) begin
            var_stamp[ctcc_pkg::AddrBits'(i)] = '0;
            var_seen[ctcc_pkg::AddrBits'(i)] = ctcc_pkg::PolNone;
         end
         clause_id = 1;
      end else begin
         clause_id = clause_id + 1'b1;
      end
   endfunction

   task automatic check_field(input string what,
                              input logic [ctcc_pkg::CountBits-1:0] want,
                              input logic [ctcc_pkg::CountBits-1:0] seen_val);
      if (want != seen_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want,
                  seen_val);
         error_count++;
      end
   endtask

   // Literal driver: offers queued literals, holds them while stalled, and
   // inserts idle bursts when enabled.
   always @(posedge clock) begin : literal_driver
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tally_literal(req_literal);
            literals_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 && !quiet) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sender_idle && !quiet && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else if (pending_literals.size() > 0) begin
               req_valid <= 1'b1;
               req_literal <= pending_literals.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted transaction against the oldest
   // prediction and drives the receiver stall.
   always @(posedge clock) begin : verdict_monitor
      ctcc_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_verdicts.size() == 0) begin
               $display("%0t: result with no prediction pending, actual count %0d/%0d",
                        $time, rsp_tautology_count, rsp_other_count);
               error_count++;
            end else begin
               want = predicted_verdicts.pop_front();
               check_field("clause_is_tautology",
                           ctcc_pkg::CountBits'(want.clause_is_tautology),
                           ctcc_pkg::CountBits'(rsp_clause_is_tautology));
               check_field("tautology_count", want.tautology_count, rsp_tautology_count);
               check_field("other_count", want.other_count, rsp_other_count);
               check_field("formula_done", ctcc_pkg::CountBits'(want.formula_done),
                           ctcc_pkg::CountBits'(rsp_formula_done));
               check_field("all_tautologies", ctcc_pkg::CountBits'(want.all_tautologies),
                           ctcc_pkg::CountBits'(rsp_all_tautologies));
               check_field("bad_literal_seen", ctcc_pkg::CountBits'(want.bad_literal_seen),
                           ctcc_pkg::CountBits'(rsp_bad_literal_seen));
            end
            clauses_checked++;
            taut_seen += int'(rsp_clause_is_tautology);
            done_seen += int'(rsp_formula_done);
            bad_seen += int'(rsp_bad_literal_seen);
         end

         // A requested long hold takes priority over the short random bursts.
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LongHoldCycles - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0 && !quiet) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle && !quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transaction for %0d cycles, %0d predictions pending", $time,
                  idle_cycles, predicted_verdicts.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_lit(input int v);
      pending_literals.push_back(ctcc_pkg::LitBits'(v));
   endtask

   // Waits until every literal is taken and every verdict has arrived, then
   // lets the tag pipeline settle.
   task automatic drain;
      @(negedge clock);
      while (pending_literals.size() != 0 || req_valid || predicted_verdicts.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_target(input logic [ctcc_pkg::CountBits-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clause_target = value;
   endtask

   // Queues random clauses, mostly well formed over a narrow window of
   // variables so that tautologies are common, with some raw noise.
   task automatic queue_clauses(input int n_items);
      int pushed;
      int kind;
      int len;
      int base;
      int v;
      pushed = 0;
      while (pushed < n_items) begin
         kind = $urandom_range(0, 19);
         if (kind < 2) begin
            pending_literals.push_back(ctcc_pkg::LitBits'($urandom_range(0, 8191)));
            pushed++;
         end else begin
            len = (kind < 4) ? 0 : $urandom_range(1, 6);
            base = $urandom_range(1, ctcc_pkg::MaxVars - 7);
            if (kind == 4) base = 1;
            if (kind == 5) base = ctcc_pkg::MaxVars - 7;
            for (int i = 0; i < len; i++) begin
               v = base + $urandom_range(0, 7);
               if (kind == 6 && i == len / 2) push_lit(-(1 << (ctcc_pkg::LitBits - 1)));
               else push_lit($urandom_range(0, 1) ? -v : v);
               pushed++;
            end
            push_lit(0);
            pushed++;
         end
      end
   endtask

   task automatic run_phase(input logic [ctcc_pkg::CountBits-1:0] target,
                            input int n_items, input bit s_idle, input bit r_idle);
      drain();
      write_target(target);
      sender_idle = s_idle;
      receiver_idle = r_idle;
      queue_clauses(n_items);
   endtask

   initial begin
      for (int i = 0; i < ctcc_pkg::TagDepth; i++) begin
         var_stamp[ctcc_pkg::AddrBits'(i)] = '0;
         var_seen[ctcc_pkg::AddrBits'(i)] = ctcc_pkg::PolNone;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed clauses with no formula end: empty, tautology, repeat,
      // literals after a hit, bad literal, extreme variables.
      write_target(0);
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      push_lit(0);
      push_lit(5); push_lit(-5); push_lit(0);
      push_lit(7); push_lit(7); push_lit(0);
      push_lit(3); push_lit(-3); push_lit(3); push_lit(9); push_lit(0);
      push_lit(-4096); push_lit(0);
      push_lit(4095); push_lit(-4095); push_lit(0);
      push_lit(-1); push_lit(1); push_lit(-4096); push_lit(0);

      // One clause per formula: each result finishes one and restarts.
      drain();
      write_target(1);
      push_lit(2); push_lit(-2); push_lit(0);
      push_lit(0);
      push_lit(-2048); push_lit(2048); push_lit(0);
      queue_clauses(50);

      run_phase(3, 150, 1'b1, 1'b1);
      run_phase(24'hFFFFFF, 150, 1'b0, 1'b1);

      // Receiver holds off while the sender keeps offering short clauses.
      drain();
      write_target(2);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      holds_asked++;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 0) begin
            push_lit(i + 1);
            push_lit(-(i + 1));
         end
         push_lit(0);
      end

      // A large target, then one below the count already reached.
      run_phase(60, 150, 1'b1, 1'b0);
      run_phase(4, 100, 1'b1, 1'b1);
      run_phase(ctcc_pkg::CountBits'($urandom_range(5, 30)), 200, 1'b1, 1'b1);
      run_phase(1, 100, 1'b0, 1'b0);
      for (int p = 0; p < 3; p++)
         run_phase(ctcc_pkg::CountBits'($urandom_range(0, 12)), 150,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      // Closing stretch at full rate on both channels.
      drain();
      quiet = 1'b1;
      write_target(7);
      queue_clauses(200);
      drain();
      repeat (20) @(posedge clock);

      $display("Accepted %0d literals and checked %0d clause verdicts.", literals_accepted,
               clauses_checked);
      $display("Tautologies %0d, formulas completed %0d, clauses with bad literals %0d.",
               taut_seen, done_seen, bad_seen);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
